// ----- rtl/core/xmodem_receiver_defines.svh -----
// Assertion macros for the XMODEM receiver.
`ifndef XMODEM_RECEIVER_DEFINES_SVH
`define XMODEM_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
`define XMR_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define XMR_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define XMR_ASSERT_IMP(lbl, clk, rst, a, c)
`define XMR_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

// ----- rtl/core/xmr_pkg.sv -----
// Types and constants shared by the XMODEM receiver modules.
`timescale 1ns / 1ps
`default_nettype none
package xmr_pkg;
  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC, PH_CANW, PH_RECV, PH_FLUSH, PH_DONE
  } phase_t;
  typedef enum logic [1:0] {TM_C, TM_NAK, TM_NONE} try_mode_t;
  typedef enum logic [1:0] {AF_NAK, AF_ACK_END, AF_ACK_CAN, AF_CANCEL} after_t;
  typedef enum logic [1:0] {FN_BYTE, FN_TICK, FN_START, FN_NONE} func_t;
  localparam logic [2:0] IDX_READ_TIMEOUT = 3'd0;
  localparam logic [2:0] IDX_FLUSH_QUIET  = 3'd1;
  localparam logic [2:0] IDX_SYNC_WAIT    = 3'd2;
  localparam logic [2:0] IDX_MAX_DUPES    = 3'd3;
  localparam logic [2:0] IDX_DEST_SIZE    = 3'd4;
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;
  localparam logic [1:0] V_NONE = 2'd0;
  localparam logic [1:0] V_COMMIT = 2'd1;
  localparam logic [1:0] V_DISCARD = 2'd2;
  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_REMOTE = 3'd2;
  localparam logic [2:0] ST_SYNC = 3'd3;
  localparam logic [2:0] ST_DUPES = 3'd4;

  // One queued command: up to three results with shared status and total.
  typedef struct packed {
    logic [1:0]  count;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [1:0]  verdict;
    logic [2:0]  status;
    logic [30:0] total_bytes;
  } cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [1:0]  packet_verdict;
    logic [2:0]  status;
    logic [30:0] total_bytes;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/xmr_front.sv -----
// Protocol engine: takes items, updates session state and issues result commands.
`timescale 1ns / 1ps
`default_nettype none
module xmr_front #(
  parameter int TRIES_PER_PHASE = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  output logic                    cmd_valid,
  output xmr_pkg::cmd_t           cmd,
  input  wire logic               cmd_ready
);
  import xmr_pkg::*;

  logic [15:0] read_timeout, flush_quiet, sync_wait;
  logic [4:0]  max_dupes;
  logic [30:0] dest_size;

  phase_t      phase, phase_next;
  try_mode_t   try_mode, try_mode_next;
  after_t      after_flush, after_flush_next;
  logic [4:0]  try_count, try_count_next;
  logic        crc_mode, crc_mode_next, big_block, big_block_next;
  logic [10:0] byte_index, byte_index_next, pending_len, pending_len_next;
  logic [7:0]  expected_block, expected_block_next, got_block, got_block_next;
  logic [1:0]  header_flags, header_flags_next;
  logic [4:0]  dupes_left, dupes_left_next;
  logic [30:0] committed_len, committed_len_next;
  logic [15:0] running_crc, running_crc_next, silence_timer, silence_timer_next;
  logic [7:0]  running_sum, running_sum_next, check_hold, check_hold_next;
  logic [2:0]  cancel_code, cancel_code_next, status, status_next;
  cmd_t        c;
  logic        fire;

  assign in_ready = !cmd_valid || cmd_ready;
  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_timeout <= 16'd1000;
      flush_quiet <= 16'd3000;
      sync_wait <= 16'd3000;
      max_dupes <= 5'd25;
      dest_size <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        IDX_READ_TIMEOUT: read_timeout <= cfg_data[15:0];
        IDX_FLUSH_QUIET:  flush_quiet <= cfg_data[15:0];
        IDX_SYNC_WAIT:    sync_wait <= cfg_data[15:0];
        IDX_MAX_DUPES:    max_dupes <= cfg_data[4:0];
        IDX_DEST_SIZE:    dest_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] tinc, limit;
    logic [10:0] i, bufsz;
    logic        emit_tx, check_ok, hdr_ok, do_end, do_tick;
    logic [31:0] sum_len;
    phase_next = phase; try_mode_next = try_mode; after_flush_next = after_flush;
    try_count_next = try_count; crc_mode_next = crc_mode; big_block_next = big_block;
    byte_index_next = byte_index; pending_len_next = pending_len;
    expected_block_next = expected_block; got_block_next = got_block;
    header_flags_next = header_flags; dupes_left_next = dupes_left;
    committed_len_next = committed_len; running_crc_next = running_crc;
    silence_timer_next = silence_timer; running_sum_next = running_sum;
    check_hold_next = check_hold; cancel_code_next = cancel_code; status_next = status;
    c = '0;
    c.count = 2'd1;
    emit_tx = 1'b0;
    check_ok = 1'b0;
    do_end = 1'b0;
    hdr_ok = 1'b0;
    i = byte_index;
    bufsz = big_block ? 11'd1024 : 11'd128;
    sum_len = {1'b0, committed_len} + {21'd0, i - 11'd2};
    tinc = (silence_timer != 16'hFFFF) ? silence_timer + 16'd1 : silence_timer;
    case (phase)
      PH_SYNC: limit = sync_wait;
      PH_FLUSH: limit = flush_quiet;
      default: limit = read_timeout;
    endcase
    do_tick = 1'b0;
    case (func_t'(func))
      FN_START: begin
        if (phase == PH_RECV && pending_len != 0) c.verdict = V_DISCARD;
        phase_next = PH_SYNC; try_mode_next = TM_C; try_count_next = '0;
        crc_mode_next = 1'b0; big_block_next = 1'b0; byte_index_next = '0;
        expected_block_next = 8'd1; got_block_next = '0; header_flags_next = '0;
        dupes_left_next = max_dupes; committed_len_next = '0; pending_len_next = '0;
        running_crc_next = '0; running_sum_next = '0; check_hold_next = '0;
        silence_timer_next = '0; after_flush_next = AF_NAK; cancel_code_next = ST_SYNC;
        status_next = ST_RUN;
        c.tx_valid = 1'b1; c.tx_byte = B_C;
      end
      FN_BYTE: begin
        case (phase)
          PH_SYNC: begin
            if (rx_byte == B_SOH || rx_byte == B_STX) begin
              big_block_next = (rx_byte == B_STX);
              if (try_mode == TM_C) crc_mode_next = 1'b1;
              try_mode_next = TM_NONE; phase_next = PH_RECV; byte_index_next = '0;
              header_flags_next = '0; pending_len_next = '0; running_crc_next = '0;
              running_sum_next = '0; silence_timer_next = '0;
            end else if (rx_byte == B_EOT) begin
              phase_next = PH_FLUSH; after_flush_next = AF_ACK_END; silence_timer_next = '0;
            end else if (rx_byte == B_CAN) begin
              phase_next = PH_CANW; silence_timer_next = '0;
            end else do_end = 1'b1;
          end
          PH_CANW: begin
            if (rx_byte == B_CAN) begin
              phase_next = PH_FLUSH; after_flush_next = AF_ACK_CAN; silence_timer_next = '0;
            end else do_end = 1'b1;
          end
          PH_RECV: begin
            silence_timer_next = '0;
            byte_index_next = i + 11'd1;
            if (i == 11'd0) got_block_next = rx_byte;
            else if (i == 11'd1) begin
              hdr_ok = (got_block == ~rx_byte) &&
                       (got_block == expected_block || got_block == expected_block - 8'd1);
              header_flags_next = {hdr_ok && got_block == expected_block, hdr_ok};
            end else if (i < bufsz + 11'd2) begin
              running_crc_next = crc_add(running_crc, rx_byte);
              running_sum_next = running_sum + rx_byte;
              if (header_flags[1] && sum_len < {1'b0, dest_size}) begin
                pending_len_next = pending_len + 11'd1;
                c.data_valid = 1'b1; c.data_byte = rx_byte;
              end
            end else if (crc_mode && i == bufsz + 11'd2) check_hold_next = rx_byte;
            else begin
              check_ok = crc_mode ? (running_crc == {check_hold, rx_byte})
                                  : (running_sum == rx_byte);
              pending_len_next = '0;
              if (!check_ok || !header_flags[0]) begin
                if (pending_len != 0) c.verdict = V_DISCARD;
                phase_next = PH_FLUSH; after_flush_next = AF_NAK; silence_timer_next = '0;
              end else begin
                if (header_flags[1]) begin
                  committed_len_next = committed_len + {20'd0, pending_len};
                  if (pending_len != 0) c.verdict = V_COMMIT;
                  expected_block_next = expected_block + 8'd1;
                  dupes_left_next = max_dupes;
                end else begin
                  if (pending_len != 0) c.verdict = V_DISCARD;
                  dupes_left_next = dupes_left - 5'd1;
                end
                if ((header_flags[1] && max_dupes == 0) ||
                    (!header_flags[1] && dupes_left <= 5'd1)) begin
                  cancel_code_next = ST_DUPES; phase_next = PH_FLUSH;
                  after_flush_next = AF_CANCEL; silence_timer_next = '0;
                end else begin
                  c.tx_valid = 1'b1; c.tx_byte = B_ACK;
                  phase_next = PH_SYNC; try_count_next = '0; silence_timer_next = '0;
                end
              end
            end
          end
          PH_FLUSH: silence_timer_next = '0;
          default: ;
        endcase
      end
      FN_TICK: begin
        if (phase == PH_SYNC || phase == PH_CANW || phase == PH_RECV || phase == PH_FLUSH) begin
          silence_timer_next = tinc;
          do_tick = tinc >= limit;
        end
        if (do_tick) begin
          case (phase)
            PH_SYNC, PH_CANW: do_end = 1'b1;
            PH_RECV: begin
              if (pending_len != 0) c.verdict = V_DISCARD;
              pending_len_next = '0;
              phase_next = PH_FLUSH; after_flush_next = AF_NAK; silence_timer_next = '0;
            end
            PH_FLUSH: begin
              c.tx_valid = 1'b1;
              case (after_flush)
                AF_NAK: begin
                  c.tx_byte = B_NAK; phase_next = PH_SYNC; try_count_next = '0;
                  silence_timer_next = '0;
                end
                AF_ACK_END: begin
                  c.tx_byte = B_ACK; status_next = ST_COMPLETE; phase_next = PH_DONE;
                end
                AF_ACK_CAN: begin
                  c.tx_byte = B_ACK; status_next = ST_REMOTE; phase_next = PH_DONE;
                end
                default: begin
                  c.tx_byte = B_CAN; c.count = 2'd3; status_next = cancel_code;
                  phase_next = PH_DONE;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (do_end) begin
      phase_next = PH_SYNC; silence_timer_next = '0;
      try_count_next = try_count + 5'd1;
      if (try_count_next < 5'(TRIES_PER_PHASE)) begin
        emit_tx = (try_mode != TM_NONE);
        c.tx_valid = emit_tx;
        c.tx_byte = emit_tx ? ((try_mode == TM_C) ? B_C : B_NAK) : 8'd0;
      end else if (try_mode == TM_C) begin
        try_mode_next = TM_NAK; try_count_next = '0;
        c.tx_valid = 1'b1; c.tx_byte = B_NAK;
      end else begin
        cancel_code_next = ST_SYNC; phase_next = PH_FLUSH;
        after_flush_next = AF_CANCEL; silence_timer_next = '0;
      end
    end
    c.status = status_next;
    c.total_bytes = committed_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; try_mode <= TM_C; after_flush <= AF_NAK; try_count <= '0;
      crc_mode <= 1'b0; big_block <= 1'b0; byte_index <= '0; pending_len <= '0;
      expected_block <= 8'd1; got_block <= '0; header_flags <= '0;
      dupes_left <= 5'd25; committed_len <= '0; running_crc <= '0;
      silence_timer <= '0; running_sum <= '0; check_hold <= '0;
      cancel_code <= ST_SYNC; status <= ST_RUN; cmd_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase <= phase_next; try_mode <= try_mode_next; after_flush <= after_flush_next;
        try_count <= try_count_next; crc_mode <= crc_mode_next;
        big_block <= big_block_next; byte_index <= byte_index_next;
        pending_len <= pending_len_next; expected_block <= expected_block_next;
        got_block <= got_block_next; header_flags <= header_flags_next;
        dupes_left <= dupes_left_next; committed_len <= committed_len_next;
        running_crc <= running_crc_next; silence_timer <= silence_timer_next;
        running_sum <= running_sum_next; check_hold <= check_hold_next;
        cancel_code <= cancel_code_next; status <= status_next;
      end
      if (fire) cmd_valid <= 1'b1;
      else if (cmd_ready) cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) cmd <= c;
  end
endmodule
`default_nettype wire

// ----- rtl/core/xmr_back.sv -----
// Result sequencer: turns each queued command into one to three result items.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_receiver_defines.svh"
module xmr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire xmr_pkg::cmd_t cmd,
  output logic               cmd_ready,
  output logic               out_valid,
  output xmr_pkg::result_t   res,
  input  wire logic          out_ready
);
  import xmr_pkg::*;

  logic [1:0] sent;
  logic       is_last;

  assign out_valid = cmd_valid;
  assign is_last = (sent + 2'd1) == cmd.count;
  assign cmd_ready = out_ready && is_last;

  always_comb begin
    res.tx_valid = cmd.tx_valid;
    res.tx_byte = cmd.tx_byte;
    res.data_valid = cmd.data_valid;
    res.data_byte = cmd.data_byte;
    res.packet_verdict = cmd.verdict;
    res.status = cmd.status;
    res.total_bytes = cmd.total_bytes;
    res.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (cmd_valid && out_ready) begin
      sent <= is_last ? 2'd0 : sent + 2'd1;
    end
  end

  `XMR_ASSERT_IMP(a_count_ok, clk, rst, cmd_valid, cmd.count == 2'd1 || cmd.count == 2'd3)
  `XMR_ASSERT_IMP(a_sent_below, clk, rst, cmd_valid, sent < cmd.count)
  `XMR_ASSERT_NEXT(a_sent_clear, clk, rst, cmd_valid && out_ready && is_last, sent == 2'd0)
endmodule
`default_nettype wire

// ----- rtl/core/xmodem_receiver.sv -----
// Top level of the XMODEM receiver.
//   channel  dir  fields (low bit first)
//   s_axis   in   tdata: func[1:0], rx_byte[9:2]
//   m_axis   out  tdata: tx_valid, tx_byte, data_valid, data_byte, verdict,
//                 status, total_bytes; tlast: last
//   cfg      in   cfg_we, cfg_index, cfg_data
// The front engine takes one item per cycle into a one-entry command register, unless the output stalls.
// Each command yields one result item, or three for a cancel run.
// A stalled output holds the command register and so stalls the input.
// Reset is synchronous and leaves the session idle with default registers.
`timescale 1ns / 1ps
`default_nettype none
module xmodem_receiver #(
  parameter int TRIES_PER_PHASE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // func[1:0], rx_byte[9:2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tx_valid[0], tx_byte[8:1], data_valid[9], data_byte[17:10],
  // packet_verdict[19:18], status[22:20], total_bytes[53:23]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);
  import xmr_pkg::*;

  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  result_t res;

  xmr_front #(.TRIES_PER_PHASE(TRIES_PER_PHASE)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .func(s_axis_tdata[1:0]), .rx_byte(s_axis_tdata[9:2]),
    .cfg_we, .cfg_index, .cfg_data, .cmd_valid, .cmd, .cmd_ready
  );

  xmr_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_ready,
    .out_valid(m_axis_tvalid), .res, .out_ready(m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res.total_bytes, res.status, res.packet_verdict,
                         res.data_byte, res.data_valid, res.tx_byte, res.tx_valid};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire
